// ===== hdl/adsr_pkg.sv =====
`default_nettype none
package adsr_pkg;

  // fixed-point format of levels: unsigned Q1.15
  localparam int FRAC_BITS  = 15;
  localparam int LEVEL_W    = 16;
  localparam int LEN_W      = 24;
  localparam int SAMPLE_W   = 16;
  localparam int ADV_W      = 8;
  localparam int PROD_W     = LEN_W + LEVEL_W;
  localparam int DIV_STEPS  = LEVEL_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [LEVEL_W-1:0] UNITY = LEVEL_W'(32'd1 << FRAC_BITS);

  localparam logic [LEN_W-1:0]   ATTACK_RESET  = LEN_W'(480);
  localparam logic [LEN_W-1:0]   DECAY_RESET   = LEN_W'(12000);
  localparam logic [LEVEL_W-1:0] SUSTAIN_RESET = LEVEL_W'(8192);
  localparam logic [LEN_W-1:0]   RELEASE_RESET = LEN_W'(24000);

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_ATTACK  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_OFF     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LEVEL,
    ST_WRITE
  } ctrl_state_t;

  typedef struct packed {
    logic [LEN_W-1:0]   attack_length;
    logic [LEN_W-1:0]   decay_length;
    logic [LEVEL_W-1:0] sustain_level;
    logic [LEN_W-1:0]   release_length;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic div_step;
    logic level_en;
    logic write_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_sample;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== hdl/adsr_regs.sv =====
`default_nettype none
module adsr_regs (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [adsr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire  [adsr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [adsr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output adsr_pkg::cfg_t                      cfg
);
  import adsr_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_length  <= ATTACK_RESET;
      cfg.decay_length   <= DECAY_RESET;
      cfg.sustain_level  <= SUSTAIN_RESET;
      cfg.release_length <= RELEASE_RESET;
    end else if (wr) begin
      case (idx)
        REG_ATTACK:  cfg.attack_length  <= pwdata[LEN_W-1:0];
        REG_DECAY:   cfg.decay_length   <= pwdata[LEN_W-1:0];
        REG_SUSTAIN: cfg.sustain_level  <= pwdata[LEVEL_W-1:0];
        REG_RELEASE: cfg.release_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ATTACK:  prdata = CFG_DATA_W'(cfg.attack_length);
      REG_DECAY:   prdata = CFG_DATA_W'(cfg.decay_length);
      REG_SUSTAIN: prdata = CFG_DATA_W'(cfg.sustain_level);
      REG_RELEASE: prdata = CFG_DATA_W'(cfg.release_length);
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/adsr_ctrl.sv =====
`default_nettype none
module adsr_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  adsr_pkg::ctrl_sts_t  sts,
  output adsr_pkg::ctrl_cmd_t  cmd
);
  import adsr_pkg::*;

  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_last;

  assign div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end else begin
        div_cnt <= '0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && sts.in_is_sample) state_next = ST_MUL;
      end
      ST_MUL:   state_next = ST_DIV;
      ST_DIV: begin
        if (div_last) state_next = ST_LEVEL;
      end
      ST_LEVEL: state_next = ST_WRITE;
      ST_WRITE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.accept    = s_axis_tvalid;
      end
      ST_MUL:   cmd.mul_en   = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_LEVEL: cmd.level_en = 1'b1;
      ST_WRITE: cmd.write_en = sts.out_free;
      default: ;
    endcase
  end

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    cmd.write_en |-> sts.out_free)
    else $error("result written while output register is full");

  a_sample_to_mul: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.in_is_sample) |=> cmd.mul_en)
    else $error("accepted sample did not start the multiply");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en |=> (cmd.div_step && div_cnt == '0))
    else $error("divide did not start at step zero");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && div_last) |=> cmd.level_en)
    else $error("level not formed after last divide step");

endmodule
`default_nettype wire

// ===== hdl/adsr_dp.sv =====
`default_nettype none
module adsr_dp #(
  parameter int POSITION_BITS = 24
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  adsr_pkg::cfg_t                       cfg,
  input  adsr_pkg::ctrl_cmd_t                  cmd,
  output adsr_pkg::ctrl_sts_t                  sts,
  input  wire  [adsr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  wire  [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [adsr_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import adsr_pkg::*;

  localparam int CMP_W = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;

  // envelope state
  phase_t                    phase_reg;
  logic [POSITION_BITS-1:0]  position;
  logic [LEVEL_W-1:0]        current_level;
  logic [LEVEL_W-1:0]        release_start_level;

  // per-item working registers
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [ADV_W-1:0]           advance_r;
  phase_t                     phase_before;
  logic [LEN_W-1:0]           rem;
  logic [LEVEL_W-1:0]         quo;
  logic [LEVEL_W-1:0]         level_r;

  kind_t                      kind;
  logic [LEN_W-1:0]           len_sel;
  logic                       len_zero;
  logic [CMP_W-1:0]           pos_ext;
  logic [CMP_W-1:0]           len_ext;
  logic [LEN_W-1:0]           p_cl;
  logic [LEVEL_W-1:0]         s_cl;
  logic [LEN_W-1:0]           mul_a;
  logic [LEVEL_W-1:0]         mul_b;
  logic [PROD_W-1:0]          prod;
  logic [LEN_W:0]             trial;
  logic                       trial_ge;
  logic [LEVEL_W-1:0]         level_sel;
  logic [POSITION_BITS:0]     pos_sum;
  logic [POSITION_BITS-1:0]   pos_sat;
  logic [CMP_W-1:0]           pos_sat_ext;
  logic                       phase_done;
  phase_t                     phase_next;
  logic [POSITION_BITS-1:0]   pos_next;
  logic signed [SAMPLE_W+LEVEL_W:0] scaled;

  assign kind             = kind_t'(s_axis_tuser);
  assign sts.in_is_sample = (kind == KIND_SAMPLE);
  assign sts.out_free     = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    case (phase_reg)
      PH_ATTACK:  len_sel = cfg.attack_length;
      PH_DECAY:   len_sel = cfg.decay_length;
      PH_RELEASE: len_sel = cfg.release_length;
      default:    len_sel = '0;
    endcase
  end

  assign len_zero = (len_sel == '0);
  assign pos_ext  = CMP_W'(position);
  assign len_ext  = CMP_W'(len_sel);
  assign p_cl     = (pos_ext > len_ext) ? len_sel : pos_ext[LEN_W-1:0];
  assign s_cl     = (cfg.sustain_level > UNITY) ? UNITY : cfg.sustain_level;

  // numerator of the level ramp
  always_comb begin
    case (phase_reg)
      PH_ATTACK: begin
        mul_a = p_cl;
        mul_b = UNITY;
      end
      PH_DECAY: begin
        mul_a = p_cl;
        mul_b = UNITY - s_cl;
      end
      PH_RELEASE: begin
        mul_a = len_sel - p_cl;
        mul_b = release_start_level;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // restoring divide step, quotient shifts in below the numerator bits
  assign trial    = {rem, quo[LEVEL_W-1]};
  assign trial_ge = (trial >= {1'b0, len_sel});

  always_comb begin
    case (phase_reg)
      PH_ATTACK:  level_sel = len_zero ? UNITY : quo;
      PH_DECAY:   level_sel = len_zero ? UNITY : (UNITY - quo);
      PH_SUSTAIN: level_sel = s_cl;
      PH_RELEASE: level_sel = len_zero ? '0 : quo;
      default:    level_sel = '0;
    endcase
  end

  // position advance with saturation and phase end
  assign pos_sum     = {1'b0, position} + (POSITION_BITS + 1)'(advance_r);
  assign pos_sat     = pos_sum[POSITION_BITS] ? '1 : pos_sum[POSITION_BITS-1:0];
  assign pos_sat_ext = CMP_W'(pos_sat);
  assign phase_done  = (pos_sat_ext >= len_ext);

  always_comb begin
    phase_next = phase_reg;
    pos_next   = pos_sat;
    case (phase_reg)
      PH_ATTACK: begin
        if (phase_done) begin
          phase_next = PH_DECAY;
          pos_next   = '0;
        end
      end
      PH_DECAY: begin
        if (phase_done) begin
          phase_next = PH_SUSTAIN;
          pos_next   = '0;
        end
      end
      PH_RELEASE: begin
        if (phase_done) begin
          phase_next = PH_OFF;
          pos_next   = '0;
        end
      end
      default: ;
    endcase
  end

  assign scaled = sample_r * $signed({1'b0, level_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg           <= PH_OFF;
      position            <= '0;
      current_level       <= '0;
      release_start_level <= '0;
      m_axis_tvalid       <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (kind)
          KIND_ATTACK: begin
            phase_reg     <= PH_ATTACK;
            current_level <= '0;
            position      <= '0;
          end
          KIND_RELEASE: begin
            phase_reg           <= PH_RELEASE;
            release_start_level <= current_level;
            position            <= '0;
          end
          KIND_OFF: begin
            phase_reg <= PH_OFF;
            position  <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.write_en) begin
        current_level <= level_r;
        phase_reg     <= phase_next;
        position      <= pos_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r     <= s_axis_tdata[SAMPLE_W-1:0];
      advance_r    <= s_axis_tdata[SAMPLE_W +: ADV_W];
      phase_before <= phase_reg;
    end
    if (cmd.mul_en) begin
      rem <= prod[PROD_W-1:LEVEL_W];
      quo <= prod[LEVEL_W-1:0];
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? LEN_W'(trial - {1'b0, len_sel}) : trial[LEN_W-1:0];
      quo <= {quo[LEVEL_W-2:0], trial_ge};
    end
    if (cmd.level_en) begin
      level_r <= level_sel;
    end
    if (cmd.write_en) begin
      m_axis_tdata <= {4'b0, (phase_next != PH_OFF), phase_before, level_r,
                       scaled[FRAC_BITS+SAMPLE_W-1:FRAC_BITS]};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/adsr_envelope_generator.sv =====
`default_nettype none
// linear adsr envelope with off, attack, decay, sustain and release phases.
// items arrive on s_axis: tuser picks the kind (sample, trigger attack,
// trigger release, turn off) and a sample item gives one result on m_axis
// carrying the sample scaled by the envelope level, the level itself in
// q1.15, the phase used and whether the envelope is still running after the
// position advance. control items give no result. a sample item runs
// through accept, ramp multiply, a 16-step restoring divide by the phase
// length, level forming and scale and advance, which writes its result
// into the output register. the write step waits while the previous
// result is still unread. the next item is taken as soon as the result
// sits in the output register, even if it has not been taken yet.
// registers sit on the apb port at byte addresses 0 (attack length), 4
// (decay length), 8 (sustain level) and 12 (release length) and must only
// be written while no sample is in flight.
module adsr_envelope_generator #(
  parameter int POSITION_BITS = 24
) (
  input  wire         clk,
  input  wire         rst,
  // apb configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,  // sample_in[15:0], advance[23:16]
  input  wire  [1:0]  s_axis_tuser,  // kind[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata   // sample_out[15:0], level[31:16],
                                     // phase[34:32], active[35], zero pad
);
  import adsr_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // register file
  adsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: accept, multiply, divide steps, level, write
  adsr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // envelope state, ramp arithmetic and output register
  adsr_dp #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ===== verif/tb_adsr_envelope_generator.sv =====
`timescale 1ns / 1ps
module tb_adsr_envelope_generator;
  import adsr_pkg::*;

  // position counter width of the default build
  localparam int POSITION_BITS = 24;
  localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS) - 1;
  // settle time after the last item, with margin over a sample item's run
  localparam int SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int ROUND_ITEMS = 160;

  // one input item: kind, signed sample, position advance
  typedef struct {
    kind_t       kind;
    logic [15:0] smp;
    logic [7:0]  adv;
    bit          drain;  // sender holds this item until no result is owed
  } env_cmd_t;

  // one result item as the block should give it
  typedef struct {
    logic [15:0] smp;
    logic [15:0] lvl;
    phase_t      ph;
    logic        act;
  } env_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // sample_in[15:0], advance[23:16]
  logic [1:0]  s_axis_tuser = '0;  // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // sample_out[15:0], level[31:16], phase[34:32],
                                   // active[35], zero pad

  adsr_envelope_generator dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // items waiting to be sent, and results owed by the block
  env_cmd_t    env_cmds_pending[$];
  env_result_t expected_outs[$];

  // predictor copy of the registers
  logic [23:0] cfg_attack  = ATTACK_RESET;
  logic [23:0] cfg_decay   = DECAY_RESET;
  logic [15:0] cfg_sustain = SUSTAIN_RESET;
  logic [23:0] cfg_release = RELEASE_RESET;

  // predictor copy of the envelope state
  phase_t      env_phase     = PH_OFF;
  logic [23:0] env_pos       = '0;
  logic [15:0] env_level     = '0;
  logic [15:0] env_rel_start = '0;

  int          send_idle_pct = 35;
  int          recv_idle_pct = 57;
  int          error_count = 0;
  int unsigned cycle_count = 0;
  logic        in_taken = 1'b0;
  env_cmd_t    drive_cmd;
  env_cmd_t    seen_cmd;
  env_result_t want;

  task automatic report_mismatch(string what, longint got_v, longint want_v);
    if (error_count < 100)
      $display("[%0t] %s: got %0h, want %0h", $time, what, got_v, want_v);
    error_count++;
  endtask

  // envelope level from phase and position, sustain clamped to unity
  function automatic logic [15:0] envelope_level();
    longint unsigned len, p, s, num;
    s = (cfg_sustain > UNITY) ? UNITY : cfg_sustain;
    case (env_phase)
      PH_ATTACK: begin
        len = cfg_attack;
        if (len == 0) return UNITY;
        p = (env_pos > len) ? len : env_pos;
        num = (p * UNITY) / len;
        return num[15:0];
      end
      PH_DECAY: begin
        len = cfg_decay;
        if (len == 0) return UNITY;
        p = (env_pos > len) ? len : env_pos;
        num = UNITY - (p * (UNITY - s)) / len;
        return num[15:0];
      end
      PH_SUSTAIN: return s[15:0];
      PH_RELEASE: begin
        len = cfg_release;
        if (len == 0) return '0;
        p = (env_pos > len) ? len : env_pos;
        num = (longint'(env_rel_start) * (len - p)) / len;
        return num[15:0];
      end
      default: return '0;
    endcase
  endfunction

  // apply one accepted item to the envelope, queue its result if any
  task automatic envelope_step(env_cmd_t c);
    env_result_t r;
    logic [15:0] lvl;
    longint prod;
    longint unsigned np;
    case (c.kind)
      KIND_ATTACK: begin
        env_phase = PH_ATTACK;
        env_level = '0;
        env_pos = '0;
      end
      KIND_RELEASE: begin
        // capture the last level used, whatever the phase
        env_phase = PH_RELEASE;
        env_rel_start = env_level;
        env_pos = '0;
      end
      KIND_OFF: begin
        // level is kept for a later release
        env_phase = PH_OFF;
        env_pos = '0;
      end
      default: begin
        r.ph = env_phase;
        lvl = envelope_level();
        env_level = lvl;
        // floor of sample times level over unity, then saturate
        prod = longint'($signed(c.smp)) * longint'(lvl);
        prod = prod >>> FRAC_BITS;
        if (prod > 32767) prod = 32767;
        else if (prod < -32768) prod = -32768;
        r.smp = prod[15:0];
        r.lvl = lvl;
        // advance with saturation, a timed phase ends at its length
        np = longint'(env_pos) + c.adv;
        if (np > POS_MAX) np = POS_MAX;
        env_pos = np[23:0];
        case (env_phase)
          PH_ATTACK:
            if (env_pos >= cfg_attack) begin
              env_phase = PH_DECAY;
              env_pos = '0;
            end
          PH_DECAY:
            if (env_pos >= cfg_decay) begin
              env_phase = PH_SUSTAIN;
              env_pos = '0;
            end
          PH_RELEASE:
            if (env_pos >= cfg_release) begin
              env_phase = PH_OFF;
              env_pos = '0;
            end
          default: ;
        endcase
        r.act = (env_phase != PH_OFF);
        expected_outs.push_back(r);
      end
    endcase
  endtask

  // sender: a new item goes out once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (env_cmds_pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(env_cmds_pending[0].drain && expected_outs.size() != 0)) begin
        drive_cmd = env_cmds_pending.pop_front();
        s_axis_tdata <= {drive_cmd.adv, drive_cmd.smp};
        s_axis_tuser <= drive_cmd.kind;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: predict on accepted inputs, check accepted results
  always @(posedge clk) begin
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen_cmd.kind = kind_t'(s_axis_tuser);
        seen_cmd.smp = s_axis_tdata[15:0];
        seen_cmd.adv = s_axis_tdata[23:16];
        seen_cmd.drain = 1'b0;
        envelope_step(seen_cmd);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outs.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, 0);
        end else begin
          want = expected_outs.pop_front();
          if (m_axis_tdata[15:0] !== want.smp)
            report_mismatch("sample_out", m_axis_tdata[15:0], want.smp);
          if (m_axis_tdata[31:16] !== want.lvl)
            report_mismatch("level", m_axis_tdata[31:16], want.lvl);
          if (m_axis_tdata[34:32] !== want.ph)
            report_mismatch("phase", m_axis_tdata[34:32], want.ph);
          if (m_axis_tdata[35] !== want.act)
            report_mismatch("active", m_axis_tdata[35], want.act);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_adsr_envelope_generator: done, errors");
      $finish;
    end
  end

  task automatic push_cmd(kind_t k, logic [15:0] smp, logic [7:0] adv, bit drain);
    env_cmd_t c;
    c.kind = k;
    c.smp = smp;
    c.adv = adv;
    c.drain = drain;
    env_cmds_pending.push_back(c);
  endtask

  // register write: setup then access; predictor follows at the write edge
  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ATTACK:  cfg_attack = val[23:0];
      REG_DECAY:   cfg_decay = val[23:0];
      REG_SUSTAIN: cfg_sustain = val[15:0];
      REG_RELEASE: cfg_release = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // all items sent, all results in, control items settled
  task automatic wait_idle();
    while (env_cmds_pending.size() != 0 || s_axis_tvalid || expected_outs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly short phases so notes run through every phase
  function automatic logic [23:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 14) return 24'hFFFFFF;
    if (r < 18) return 24'($urandom);
    if (r < 65) return 24'($urandom_range(64, 1));
    return 24'($urandom_range(600, 65));
  endfunction

  function automatic logic [15:0] pick_sustain();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return UNITY;
    if (r < 30) return 16'($urandom_range(65535, 32769));
    return 16'($urandom_range(32767, 0));
  endfunction

  function automatic logic [7:0] pick_advance();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'($urandom_range(255, 0));
    if (r < 75) return 8'($urandom_range(31, 0));
    return 8'($urandom_range(7, 0));
  endfunction

  // random upper bits must be dropped by the register
  task automatic cfg_randomize();
    cfg_write(REG_ATTACK,  {8'($urandom), pick_length()});
    cfg_write(REG_DECAY,   {8'($urandom), pick_length()});
    cfg_write(REG_SUSTAIN, {16'($urandom), pick_sustain()});
    cfg_write(REG_RELEASE, {8'($urandom), pick_length()});
  endtask

  task automatic push_sample();
    push_cmd(KIND_SAMPLE, 16'($urandom), pick_advance(), $urandom_range(99) == 0);
  endtask

  // notes: attack, samples, release or off, samples; some loose noise items
  task automatic gen_round(int n_items);
    int made;
    int n;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(99) < 8) begin
        push_cmd(kind_t'($urandom_range(3)), 16'($urandom), 8'($urandom), 1'b0);
        made++;
      end else begin
        if ($urandom_range(9) != 0) begin
          push_cmd(KIND_ATTACK, 16'($urandom), 8'($urandom), 1'b0);
          made++;
        end
        n = $urandom_range(30, 1);
        repeat (n) push_sample();
        made += n;
        if ($urandom_range(9) == 0) push_cmd(KIND_OFF, 16'($urandom), 8'($urandom), 1'b0);
        else push_cmd(KIND_RELEASE, 16'($urandom), 8'($urandom), 1'b0);
        made++;
        n = $urandom_range(15, 0);
        repeat (n) push_sample();
        made += n;
        if ($urandom_range(4) == 0) begin
          push_cmd(KIND_OFF, 16'($urandom), 8'($urandom), 1'b0);
          made++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: sample while off, release from off, a short note
    push_cmd(KIND_SAMPLE, 16'h7FFF, 8'hFF, 1'b0);
    push_cmd(KIND_RELEASE, 16'h0000, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h8000, 8'h00, 1'b0);
    push_cmd(KIND_ATTACK, 16'hFFFF, 8'hFF, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h7FFF, 8'hFF, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h8000, 8'hFF, 1'b0);
    push_cmd(KIND_SAMPLE, 16'hFFFF, 8'h80, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h0001, 8'h00, 1'b0);
    push_cmd(KIND_RELEASE, 16'h0000, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h5555, 8'hAA, 1'b0);
    push_cmd(KIND_SAMPLE, 16'hAAAA, 8'h55, 1'b0);
    push_cmd(KIND_OFF, 16'h0000, 8'h00, 1'b0);
    // sender holds this one until the pipeline has drained
    push_cmd(KIND_SAMPLE, 16'h3039, 8'h01, 1'b1);
    wait_idle();

    // zero lengths everywhere, sustain at unity; junk in the upper bits
    cfg_write(REG_ATTACK,  32'hFF00_0000);
    cfg_write(REG_DECAY,   32'hA500_0000);
    cfg_write(REG_SUSTAIN, 32'hFFFF_8000);
    cfg_write(REG_RELEASE, 32'h5A00_0000);
    push_cmd(KIND_ATTACK, 16'h0000, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h7FFF, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h8000, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h7FFF, 8'hFF, 1'b0);
    push_cmd(KIND_RELEASE, 16'h0000, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h1234, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h1234, 8'h00, 1'b0);
    wait_idle();

    // sustain above unity, then release left mid-way
    cfg_write(REG_DECAY,   32'h0000_0001);
    cfg_write(REG_SUSTAIN, 32'h0000_FFFF);
    cfg_write(REG_RELEASE, 32'h0000_03E8);
    push_cmd(KIND_ATTACK, 16'h0000, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h4000, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'hC000, 8'h05, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h7FFF, 8'h10, 1'b0);
    push_cmd(KIND_RELEASE, 16'h0000, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h7FFF, 8'hFF, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h8001, 8'hFF, 1'b0);
    wait_idle();

    // release shortened below the position: clamped level, then off
    cfg_write(REG_RELEASE, 32'h0000_0064);
    cfg_write(REG_ATTACK,  32'h00FF_FFFF);
    push_cmd(KIND_SAMPLE, 16'h7FFF, 8'h00, 1'b0);
    push_cmd(KIND_ATTACK, 16'h0000, 8'h00, 1'b0);
    push_cmd(KIND_SAMPLE, 16'h7FFF, 8'hFF, 1'b0);
    wait_idle();

    // random notes under three idling regimes, new settings each round
    for (int round_idx = 0; round_idx < 6; round_idx++) begin
      if (round_idx < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 57;
      end else if (round_idx < 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cfg_randomize();
      gen_round(ROUND_ITEMS);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("tb_adsr_envelope_generator: done, clean");
    end else begin
      $display("tb_adsr_envelope_generator: done, errors");
    end
    $finish;
  end

endmodule
